@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge, reset included.
`define GCM_ASSERT_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define GCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gcm_pkg.sv @@
// Shared widths, command codes and stop types of the colormap sampler.
`timescale 1ns / 1ps
package gcm_pkg;

  localparam int STOP_IDX_W = 4;
  localparam int POS_W      = 17;
  localparam int CHAN_W     = 16;
  localparam int SAMPLE_W   = 18;
  localparam int COUNT_W    = 5;
  localparam int OUT_W      = 8;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [POS_W-1:0]  POS_ONE   = 17'h10000;
  localparam logic [CHAN_W-1:0] CHAN_FULL = 16'hFFFF;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    color_t           color;
  } stop_t;

  typedef struct packed {
    logic   black;
    color_t lo;
    color_t hi;
  } bracket_t;

endpackage

@@ rtl/gcm_lookup.sv @@
// Input stage, stop table and parallel search for the bracketing stops.
`timescale 1ns / 1ps
module gcm_lookup #(
  parameter int MAX_STOPS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [gcm_pkg::COUNT_W-1:0]           stop_count_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  command_i,
  input  logic [gcm_pkg::STOP_IDX_W-1:0]        stop_index_i,
  input  logic [gcm_pkg::POS_W-1:0]             stop_position_i,
  input  gcm_pkg::color_t                       stop_color_i,
  input  logic signed [gcm_pkg::SAMPLE_W-1:0]   sample_value_i,
  input  logic                                  sample_not_finite_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [gcm_pkg::POS_W-1:0]             t_o,
  output logic                                  black_o,
  output gcm_pkg::stop_t                        lo_o,
  output gcm_pkg::stop_t                        hi_o
);
  import gcm_pkg::*;

  localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CW = $clog2(MAX_STOPS + 1);

  logic                  a_valid_q;
  logic                  a_cmd_q;
  logic [STOP_IDX_W-1:0] a_idx_q;
  stop_t                 a_stop_q;
  logic [POS_W-1:0]      a_t_q;
  logic [POS_W-1:0]      t_d;
  logic                  a_go;
  logic                  b_ready;
  logic                  b_load;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;

  logic [POS_W-1:0]      pos_q [MAX_STOPS];
  stop_t                 stop_mem [MAX_STOPS];

  logic [CW-1:0]         n_used;
  logic [MAX_STOPS-1:0]  le;
  logic [MAX_STOPS-1:0]  last_ge;
  logic                  found;
  logic [AW-1:0]         hi_idx;
  logic                  black_d;
  logic [AW-1:0]         lo_addr;
  logic [AW-1:0]         hi_addr;

  logic                  b_valid_q;
  logic [POS_W-1:0]      b_t_q;
  logic                  b_black_q;
  stop_t                 lo_q;
  stop_t                 hi_q;

  always_comb begin
    if (sample_not_finite_i || sample_value_i[SAMPLE_W-1]) begin
      t_d = '0;
    end else if (sample_value_i > $signed({1'b0, POS_ONE})) begin
      t_d = POS_ONE;
    end else begin
      t_d = sample_value_i[POS_W-1:0];
    end
  end

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_go       = a_valid_q && ((a_cmd_q == CMD_WRITE) || b_ready);
  assign in_ready_o = !a_valid_q || a_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_cmd_q        <= command_i;
      a_idx_q        <= stop_index_i;
      a_stop_q.pos   <= stop_position_i;
      a_stop_q.color <= stop_color_i;
      a_t_q          <= t_d;
    end
  end

  assign wr_en   = a_valid_q && (a_cmd_q == CMD_WRITE) && (32'(a_idx_q) < MAX_STOPS);
  assign wr_addr = AW'(a_idx_q);

  always_comb begin
    if (32'(stop_count_i) > MAX_STOPS) begin
      n_used = CW'(MAX_STOPS);
    end else begin
      n_used = CW'(stop_count_i);
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_STOPS; j++) begin
      le[j]      = a_t_q <= pos_q[j];
      last_ge[j] = (32'(n_used) == j + 1) && (a_t_q >= pos_q[j]);
    end
  end

  always_comb begin
    found  = 1'b0;
    hi_idx = '0;
    for (int j = MAX_STOPS - 1; j >= 1; j--) begin
      if ((32'(n_used) > j) && le[j]) begin
        found  = 1'b1;
        hi_idx = AW'(j);
      end
    end
    black_d = 1'b0;
    lo_addr = '0;
    hi_addr = '0;
    if (n_used == '0) begin
      black_d = 1'b1;
    end else if (le[0]) begin
      lo_addr = '0;
      hi_addr = '0;
    end else if (|last_ge) begin
      lo_addr = AW'(32'(n_used) - 1);
      hi_addr = AW'(32'(n_used) - 1);
    end else if (found) begin
      lo_addr = hi_idx - AW'(1);
      hi_addr = hi_idx;
    end else begin
      black_d = 1'b1;
    end
  end

  assign b_load = b_ready && a_valid_q && (a_cmd_q == CMD_SAMPLE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pos_q[wr_addr]    <= a_stop_q.pos;
      stop_mem[wr_addr] <= a_stop_q;
    end
    if (b_load) begin
      lo_q      <= stop_mem[lo_addr];
      hi_q      <= stop_mem[hi_addr];
      b_t_q     <= a_t_q;
      b_black_q <= black_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q && (a_cmd_q == CMD_SAMPLE);
    end
  end

  assign out_valid_o = b_valid_q;
  assign t_o         = b_t_q;
  assign black_o     = b_black_q;
  assign lo_o        = lo_q;
  assign hi_o        = hi_q;

endmodule

@@ rtl/gcm_div.sv @@
// Pipelined restoring divider for the interpolation fraction, one bit per stage.
`timescale 1ns / 1ps
module gcm_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gcm_pkg::POS_W-1:0]   t_i,
  input  logic                        black_i,
  input  gcm_pkg::stop_t              lo_i,
  input  gcm_pkg::stop_t              hi_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [FRACTION_BITS:0]      frac_o,
  output gcm_pkg::bracket_t           br_o
);
  import gcm_pkg::*;

  localparam int NST = FRACTION_BITS + 2;

  logic                     vld_q [NST];
  logic                     rdy   [NST+1];
  logic [POS_W:0]           rem_q [NST];
  logic [POS_W-1:0]         div_q [NST];
  logic [FRACTION_BITS:0]   quo_q [NST];
  bracket_t                 pay_q [NST];

  logic signed [POS_W:0]    num;
  logic signed [POS_W:0]    span;
  logic                     flat;

  assign num  = $signed({1'b0, t_i}) - $signed({1'b0, lo_i.pos});
  assign span = $signed({1'b0, hi_i.pos}) - $signed({1'b0, lo_i.pos});
  assign flat = (span <= 0) || (num <= 0);

  assign rdy[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      rem_q[0]       <= flat ? '0 : {1'b0, num[POS_W-1:0]};
      div_q[0]       <= flat ? POS_W'(1) : span[POS_W-1:0];
      quo_q[0]       <= '0;
      pay_q[0].black <= black_i;
      pay_q[0].lo    <= lo_i.color;
      pay_q[0].hi    <= hi_i.color;
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_step
    logic [POS_W:0] r_sh;
    logic           take;

    assign r_sh = (k == 1) ? rem_q[k-1] : {rem_q[k-1][POS_W-1:0], 1'b0};
    assign take = r_sh >= {1'b0, div_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_q[k-1]) begin
        rem_q[k] <= take ? (r_sh - {1'b0, div_q[k-1]}) : r_sh;
        div_q[k] <= div_q[k-1];
        quo_q[k] <= {quo_q[k-1][FRACTION_BITS-1:0], take};
        pay_q[k] <= pay_q[k-1];
      end
    end
  end

  assign out_valid_o = vld_q[NST-1];
  assign frac_o      = quo_q[NST-1];
  assign br_o        = pay_q[NST-1];

endmodule

@@ rtl/gcm_blend.sv @@
// Per-channel blend, scaling to eight bits with round half up, and output register.
`timescale 1ns / 1ps
module gcm_blend #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [FRACTION_BITS:0]      frac_i,
  input  gcm_pkg::bracket_t           br_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gcm_pkg::OUT_W-1:0]   red_o,
  output logic [gcm_pkg::OUT_W-1:0]   green_o,
  output logic [gcm_pkg::OUT_W-1:0]   blue_o
);
  import gcm_pkg::*;

  localparam int PW = CHAN_W + FRACTION_BITS + 3;
  localparam int AW = CHAN_W + FRACTION_BITS;
  localparam int XW = AW + 8;
  localparam int YW = CHAN_W + OUT_W;
  localparam logic [XW-1:0] HALF = XW'(CHAN_FULL) << (FRACTION_BITS - 1);

  logic              v1_q, v2_q, v3_q;
  logic              r1, r2, r3;
  logic              k1_q, k2_q;
  logic [CHAN_W-1:0] a_ch [3];
  logic [CHAN_W-1:0] c_ch [3];
  logic [AW-1:0]     acc_d [3];
  logic [AW-1:0]     acc_q [3];
  logic [YW-1:0]     y_d   [3];
  logic [YW-1:0]     y_q   [3];
  logic [OUT_W-1:0]  o_d   [3];
  logic [OUT_W-1:0]  o_q   [3];

  assign a_ch[0] = br_i.lo.red;
  assign a_ch[1] = br_i.lo.green;
  assign a_ch[2] = br_i.lo.blue;
  assign c_ch[0] = br_i.hi.red;
  assign c_ch[1] = br_i.hi.green;
  assign c_ch[2] = br_i.hi.blue;

  assign r3         = !v3_q || out_ready_i;
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || r2;
  assign in_ready_o = r1;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [CHAN_W:0] diff;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   sum;
    logic [XW-1:0]          x;
    logic [CHAN_W:0]        rmd;
    logic [OUT_W:0]         q;

    assign diff     = $signed({1'b0, c_ch[l]}) - $signed({1'b0, a_ch[l]});
    assign prod     = diff * $signed({1'b0, frac_i});
    assign sum      = $signed({3'b000, a_ch[l], {FRACTION_BITS{1'b0}}}) + prod;
    assign acc_d[l] = sum[AW-1:0];

    assign x      = {acc_q[l], 8'h00} - {8'h00, acc_q[l]} + HALF;
    assign y_d[l] = x[XW-1:FRACTION_BITS];

    assign rmd    = {1'b0, y_q[l][CHAN_W-1:0]} + (CHAN_W+1)'(y_q[l][YW-1:CHAN_W]);
    assign q      = {1'b0, y_q[l][YW-1:CHAN_W]} + (OUT_W+1)'(rmd >= {1'b0, CHAN_FULL});
    assign o_d[l] = k2_q ? '0 : q[OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      acc_q <= acc_d;
      k1_q  <= br_i.black;
    end
    if (r2 && v1_q) begin
      y_q  <= y_d;
      k2_q <= k1_q;
    end
    if (r3 && v2_q) begin
      o_q <= o_d;
    end
  end

  assign out_valid_o = v3_q;
  assign red_o       = o_q[0];
  assign green_o     = o_q[1];
  assign blue_o      = o_q[2];

endmodule

@@ rtl/gradient_colormap_sampler.sv @@
// Top level of the piecewise linear colormap sampler.
//
// Requests enter on in_valid_i/in_ready_o. A write request (command 0) loads one
// color stop into the table and returns nothing. A sample request (command 1)
// maps sample_value_i to an 8-bit RGB color returned on out_valid_o/out_ready_i.
// The user must write the stop count register via cfg_we_i/cfg_wdata_i only while
// the block is idle (not enforced). Stops must be ordered by non-decreasing position.
//
// Throughput is one request per cycle while out_ready_i is held high. A sample request
// is loaded into the input register at the edge that accepts it, and its color then
// passes through the table read stage, the divider stages that form the fraction one
// quotient bit per stage, and the stages for blending, scaling and output.
//
// Reset clears the stop count and all valid bits; table contents are kept
// undefined until written. When the receiver stalls, each stage holds until the
// stage after it frees up, so in_ready_o drops once the pipeline is full and no
// request is lost or repeated.
`timescale 1ns / 1ps
module gradient_colormap_sampler #(
  parameter int MAX_STOPS     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gcm_pkg::COUNT_W-1:0]           cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  command_i,
  input  logic [gcm_pkg::STOP_IDX_W-1:0]        stop_index_i,
  input  logic [gcm_pkg::POS_W-1:0]             stop_position_i,
  input  logic [gcm_pkg::CHAN_W-1:0]            stop_red_i,
  input  logic [gcm_pkg::CHAN_W-1:0]            stop_green_i,
  input  logic [gcm_pkg::CHAN_W-1:0]            stop_blue_i,
  input  logic signed [gcm_pkg::SAMPLE_W-1:0]   sample_value_i,
  input  logic                                  sample_not_finite_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [gcm_pkg::OUT_W-1:0]             red_o,
  output logic [gcm_pkg::OUT_W-1:0]             green_o,
  output logic [gcm_pkg::OUT_W-1:0]             blue_o
);
  import gcm_pkg::*;

  logic [COUNT_W-1:0]     count_q;
  color_t                 in_color;

  logic                   lk_valid;
  logic                   lk_ready;
  logic [POS_W-1:0]       lk_t;
  logic                   lk_black;
  stop_t                  lk_lo;
  stop_t                  lk_hi;

  logic                   dv_valid;
  logic                   dv_ready;
  logic [FRACTION_BITS:0] dv_frac;
  bracket_t               dv_br;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign in_color.red   = stop_red_i;
  assign in_color.green = stop_green_i;
  assign in_color.blue  = stop_blue_i;

  gcm_lookup #(
    .MAX_STOPS(MAX_STOPS)
  ) u_lookup (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .stop_count_i       (count_q),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .stop_index_i       (stop_index_i),
    .stop_position_i    (stop_position_i),
    .stop_color_i       (in_color),
    .sample_value_i     (sample_value_i),
    .sample_not_finite_i(sample_not_finite_i),
    .out_valid_o        (lk_valid),
    .out_ready_i        (lk_ready),
    .t_o                (lk_t),
    .black_o            (lk_black),
    .lo_o               (lk_lo),
    .hi_o               (lk_hi)
  );

  gcm_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (lk_valid),
    .in_ready_o (lk_ready),
    .t_i        (lk_t),
    .black_i    (lk_black),
    .lo_i       (lk_lo),
    .hi_i       (lk_hi),
    .out_valid_o(dv_valid),
    .out_ready_i(dv_ready),
    .frac_o     (dv_frac),
    .br_o       (dv_br)
  );

  gcm_blend #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dv_valid),
    .in_ready_o (dv_ready),
    .frac_i     (dv_frac),
    .br_i       (dv_br),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o)
  );

endmodule

@@ rtl/gcm_checker.sv @@
// Port-level checks of the colormap sampler and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gcm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [gcm_pkg::OUT_W-1:0]     red_o,
  input logic [gcm_pkg::OUT_W-1:0]     green_o,
  input logic [gcm_pkg::OUT_W-1:0]     blue_o
);

  `GCM_ASSERT_ALWAYS(a_reset_clears_out, clk_i, rst_ni || !out_valid_o,
    "Result valid while in reset.")

  `GCM_ASSERT_ALWAYS(a_no_result_after_reset, clk_i, $past(rst_ni) || !out_valid_o,
    "Result valid in the first cycle after reset.")

  `GCM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o,
    "Stalled result was dropped.")

  `GCM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
    $stable({red_o, green_o, blue_o}), "Stalled result changed.")

endmodule

bind gradient_colormap_sampler gcm_checker u_gcm_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the piecewise linear colormap sampler.
`timescale 1ns / 1ps
module tb_top;
  import gcm_pkg::*;

  localparam int MAX_STOPS      = 16;
  localparam int FRACTION_BITS  = 16;
  localparam int LATENCY        = FRACTION_BITS + 7;
  localparam int DRAIN_CYCLES   = LATENCY + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic                        cmd;
    logic [STOP_IDX_W-1:0]       idx;
    stop_t                       stop;
    logic signed [SAMPLE_W-1:0]  value;
    logic                        not_finite;
  } colormap_request_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb8_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [COUNT_W-1:0]         cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       command_i;
  logic [STOP_IDX_W-1:0]      stop_index_i;
  logic [POS_W-1:0]           stop_position_i;
  logic [CHAN_W-1:0]          stop_red_i;
  logic [CHAN_W-1:0]          stop_green_i;
  logic [CHAN_W-1:0]          stop_blue_i;
  logic signed [SAMPLE_W-1:0] sample_value_i;
  logic                       sample_not_finite_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [OUT_W-1:0]           red_o;
  logic [OUT_W-1:0]           green_o;
  logic [OUT_W-1:0]           blue_o;

  stop_t        shadow_stops [MAX_STOPS];
  logic [COUNT_W-1:0] shadow_count;
  rgb8_t        expected_colors [$];
  int           mismatch_count;
  int           idle_cycles;
  int           ready_hold_cycles;
  int           stall_left;
  bit           tx_gaps_on;
  bit           rx_stalls_on;

  gradient_colormap_sampler #(
    .MAX_STOPS    (MAX_STOPS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .stop_index_i       (stop_index_i),
    .stop_position_i    (stop_position_i),
    .stop_red_i         (stop_red_i),
    .stop_green_i       (stop_green_i),
    .stop_blue_i        (stop_blue_i),
    .sample_value_i     (sample_value_i),
    .sample_not_finite_i(sample_not_finite_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .red_o              (red_o),
    .green_o            (green_o),
    .blue_o             (blue_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [OUT_W-1:0] scale_channel(logic [CHAN_W-1:0] lo_ch,
                                                     logic [CHAN_W-1:0] hi_ch,
                                                     longint unsigned frac);
    longint unsigned acc;
    longint unsigned den;
    longint unsigned level;
    den = 64'(CHAN_FULL) << FRACTION_BITS;
    acc = 64'(lo_ch) << FRACTION_BITS;
    if (hi_ch >= lo_ch) begin
      acc = acc + frac * (64'(hi_ch) - 64'(lo_ch));
    end else begin
      acc = acc - frac * (64'(lo_ch) - 64'(hi_ch));
    end
    level = (acc * 510 + den) / (2 * den);
    if (level > 255) begin
      level = 255;
    end
    return level[OUT_W-1:0];
  endfunction

  function automatic rgb8_t blend_stops(color_t lo_color, color_t hi_color,
                                        longint unsigned frac);
    rgb8_t color;
    color.red   = scale_channel(lo_color.red, hi_color.red, frac);
    color.green = scale_channel(lo_color.green, hi_color.green, frac);
    color.blue  = scale_channel(lo_color.blue, hi_color.blue, frac);
    return color;
  endfunction

  function automatic rgb8_t predict_sample(logic signed [SAMPLE_W-1:0] value,
                                           logic not_finite);
    longint          t;
    longint          lo;
    longint          span;
    longint unsigned frac;
    int              n;
    t = value;
    if (not_finite) begin
      t = 0;
    end
    if (t < 0) begin
      t = 0;
    end
    if (t > 65536) begin
      t = 65536;
    end
    n = (shadow_count > MAX_STOPS) ? MAX_STOPS : int'(shadow_count);
    if (n == 0) begin
      return '0;
    end
    if (t <= longint'(shadow_stops[0].pos)) begin
      return blend_stops(shadow_stops[0].color, shadow_stops[0].color, 0);
    end
    if (t >= longint'(shadow_stops[n-1].pos)) begin
      return blend_stops(shadow_stops[n-1].color, shadow_stops[n-1].color, 0);
    end
    for (int i = 1; i < n; i++) begin
      if (t <= longint'(shadow_stops[i].pos)) begin
        lo   = longint'(shadow_stops[i-1].pos);
        span = longint'(shadow_stops[i].pos) - lo;
        frac = 0;
        if (span > 0 && t > lo) begin
          frac = ((t - lo) << FRACTION_BITS) / span;
          if (frac > (64'd1 << FRACTION_BITS)) begin
            frac = 64'd1 << FRACTION_BITS;
          end
        end
        return blend_stops(shadow_stops[i-1].color, shadow_stops[i].color, frac);
      end
    end
    return '0;
  endfunction

  function automatic void accept_request(colormap_request_t req);
    if (req.cmd == CMD_WRITE) begin
      if (req.idx < MAX_STOPS) begin
        shadow_stops[req.idx] = req.stop;
      end
    end else begin
      expected_colors.insert(expected_colors.size(),
                             predict_sample(req.value, req.not_finite));
    end
  endfunction

  function automatic logic [CHAN_W-1:0] random_channel();
    case ($urandom_range(0, 3))
      0: begin
        return '0;
      end
      1: begin
        return CHAN_FULL;
      end
      default: begin
        return CHAN_W'($urandom);
      end
    endcase
  endfunction

  function automatic colormap_request_t make_write(logic [STOP_IDX_W-1:0] idx,
                                                   logic [POS_W-1:0] pos,
                                                   logic [CHAN_W-1:0] red,
                                                   logic [CHAN_W-1:0] green,
                                                   logic [CHAN_W-1:0] blue);
    colormap_request_t req;
    req.cmd              = CMD_WRITE;
    req.idx              = idx;
    req.stop.pos         = pos;
    req.stop.color.red   = red;
    req.stop.color.green = green;
    req.stop.color.blue  = blue;
    req.value            = SAMPLE_W'($urandom);
    req.not_finite       = 1'($urandom);
    return req;
  endfunction

  function automatic colormap_request_t make_sample(logic signed [SAMPLE_W-1:0] value,
                                                    logic not_finite);
    colormap_request_t req;
    req.cmd              = CMD_SAMPLE;
    req.idx              = STOP_IDX_W'($urandom);
    req.stop.pos         = POS_W'($urandom);
    req.stop.color.red   = CHAN_W'($urandom);
    req.stop.color.green = CHAN_W'($urandom);
    req.stop.color.blue  = CHAN_W'($urandom);
    req.value            = value;
    req.not_finite       = not_finite;
    return req;
  endfunction

  // Returns at the rising edge that accepted the request.
  task automatic send_request(colormap_request_t req);
    @(negedge clk_i);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    command_i           <= req.cmd;
    stop_index_i        <= req.idx;
    stop_position_i     <= req.stop.pos;
    stop_red_i          <= req.stop.color.red;
    stop_green_i        <= req.stop.color.green;
    stop_blue_i         <= req.stop.color.blue;
    sample_value_i      <= req.value;
    sample_not_finite_i <= req.not_finite;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    accept_request(req);
  endtask

  task automatic wait_for_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_colors.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_stop_count(logic [COUNT_W-1:0] value);
    wait_for_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    shadow_count  = value;
  endtask

  task automatic test_no_stops();
    send_request(make_sample(18'h1FFFF, 1'b0));
    send_request(make_sample(18'h20000, 1'b1));
  endtask

  task automatic test_stop_table();
    send_request(make_write(4'd0, 17'h04000, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_write(4'd1, 17'h0C000, CHAN_FULL, 16'h0000, 16'h8000));
    send_request(make_write(4'd2, 17'h08000, 16'h1234, CHAN_FULL, 16'h7FFF));
    send_request(make_write(4'd3, POS_ONE, CHAN_FULL, CHAN_FULL, CHAN_FULL));
    write_stop_count(5'd4);
    send_request(make_sample(18'h20000, 1'b0));
    send_request(make_sample(18'h1FFFF, 1'b1));
    send_request(make_sample(18'h04000, 1'b0));
    send_request(make_sample(18'h06000, 1'b0));
    send_request(make_sample(18'h0E000, 1'b0));
    send_request(make_sample(18'h10000, 1'b0));
    send_request(make_sample(18'h1FFFF, 1'b0));
  endtask

  task automatic test_duplicate_and_wide_stops();
    send_request(make_write(4'd2, 17'h0C000, 16'h00FF, 16'h8080, CHAN_FULL));
    send_request(make_write(4'd3, 17'h1FFFF, 16'hFF00, 16'h0001, 16'h0000));
    send_request(make_sample(18'h0C000, 1'b0));
    send_request(make_sample(18'h0C001, 1'b0));
    send_request(make_sample(18'h10000, 1'b0));
  endtask

  task automatic test_output_backpressure();
    tx_gaps_on        = 1'b0;
    ready_hold_cycles = 300;
    repeat (60) begin
      send_request(make_sample(SAMPLE_W'($urandom_range(0, 65536)), 1'b0));
    end
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_single_stop();
    write_stop_count(5'd1);
    send_request(make_sample(18'h08000, 1'b0));
  endtask

  task automatic test_random_gradients();
    int                         stop_counts[12];
    int                         pos;
    int                         near;
    bit                         unordered;
    bit                         wide;
    logic [STOP_IDX_W-1:0]      idx;
    logic [POS_W-1:0]           new_pos;
    logic signed [SAMPLE_W-1:0] value;
    stop_counts = '{16, 31, 0, 1, 2, 17, 16, 8, 5, 16, 31, 16};
    for (int phase = 0; phase < 12; phase++) begin
      tx_gaps_on   = (phase < 10);
      rx_stalls_on = (phase < 10);
      unordered    = (phase % 4 == 3);
      wide         = (phase % 5 == 4);
      write_stop_count(COUNT_W'(stop_counts[phase]));
      pos = 0;
      for (int i = 0; i < MAX_STOPS; i++) begin
        if (unordered) begin
          new_pos = POS_W'($urandom);
        end else begin
          if ($urandom_range(0, 3) != 0) begin
            pos = pos + $urandom_range(1, 8192);
          end
          if (pos > 65536) begin
            pos = 65536;
          end
          new_pos = POS_W'(pos);
          if (wide && i == MAX_STOPS - 1) begin
            new_pos = POS_W'($urandom_range(65537, 131071));
          end
        end
        send_request(make_write(STOP_IDX_W'(i), new_pos, random_channel(),
                                random_channel(), random_channel()));
      end
      repeat (150) begin
        if ($urandom_range(0, 99) < 12) begin
          idx     = STOP_IDX_W'($urandom);
          new_pos = shadow_stops[idx].pos;
          if ($urandom_range(0, 3) == 0) begin
            new_pos = POS_W'($urandom);
          end
          send_request(make_write(idx, new_pos, random_channel(), random_channel(),
                                  random_channel()));
        end else begin
          case ($urandom_range(0, 9))
            0, 1: begin
              value = SAMPLE_W'($urandom);
            end
            2, 3, 4, 5, 6: begin
              value = SAMPLE_W'($urandom_range(0, 65536));
            end
            default: begin
              near  = int'(shadow_stops[$urandom_range(0, MAX_STOPS - 1)].pos);
              near  = near + $urandom_range(0, 4) - 2;
              value = SAMPLE_W'(near);
            end
          endcase
          send_request(make_sample(value, $urandom_range(0, 15) == 0));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    rgb8_t expected;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected color %0d/%0d/%0d with no sample pending",
                   red_o, green_o, blue_o);
        end
      end else begin
        expected = expected_colors.pop_front();
        if (red_o !== expected.red || green_o !== expected.green ||
            blue_o !== expected.blue) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("color mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     expected.red, expected.green, expected.blue,
                     red_o, green_o, blue_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (ready_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        ready_hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        stall_left   = $urandom_range(0, 13);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni              = 1'b1;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    in_valid_i          = 1'b0;
    command_i           = CMD_WRITE;
    stop_index_i        = '0;
    stop_position_i     = '0;
    stop_red_i          = '0;
    stop_green_i        = '0;
    stop_blue_i         = '0;
    sample_value_i      = '0;
    sample_not_finite_i = 1'b0;
    shadow_count        = '0;
    mismatch_count      = 0;
    idle_cycles         = 0;
    ready_hold_cycles   = 0;
    tx_gaps_on          = 1'b1;
    rx_stalls_on        = 1'b1;
    #1;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_no_stops();
    test_stop_table();
    test_duplicate_and_wide_stops();
    test_output_backpressure();
    test_single_stop();
    test_random_gradients();
    wait_for_idle();
    if (mismatch_count == 0 && expected_colors.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
